/* hdl/vn_pkg.sv */
// Shared types and widths for the vector normalizer.
package vn_pkg;

  localparam int CW     = 32;          // component and length width
  localparam int REG_W  = 32;          // min_length register width
  localparam int SUM_W  = 2 * CW;      // exact sum of squares
  localparam int ROOT_W = CW;          // integer square root width
  localparam int DQ_W   = CW - 1;      // quotient bits, value at most 2**(CW-2)
  localparam int REM_W  = CW + 1;      // divider partial remainder

  typedef struct packed {
    logic signed [CW-1:0] x_in;
    logic signed [CW-1:0] y_in;
    logic signed [CW-1:0] z_in;
  } vec_in_t;

  typedef struct packed {
    logic signed [CW-1:0] x_out;
    logic signed [CW-1:0] y_out;
    logic signed [CW-1:0] z_out;
    logic        [CW-1:0] length;
    logic                 too_short;
  } vec_out_t;

endpackage

/* hdl/vector3_normalize.sv */
// Throughput: one vector per cycle; the whole pipeline advances together and
// holds when the output register is full and not taken.
// Stages: magnitude, square, sum, 32 square-root steps, threshold compare,
// 31 quotient steps for three parallel dividers, sign restore.
// Reset (rst, synchronous) clears all valid bits and min_length.
module vector3_normalize (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  vn_pkg::vec_in_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output vn_pkg::vec_out_t out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [31:0]      cfg_data
);
  import vn_pkg::*;

  localparam int SQ_N  = ROOT_W;
  localparam int DIV_N = DQ_W;

  logic             en;
  logic [REG_W-1:0] min_length;

  // Front stages.
  logic                  v0, v1, v2;
  logic [2:0][CW-1:0]    mag0, mag1, mag2;
  logic [2:0]            neg0, neg1, neg2;
  logic [2:0][SUM_W-1:0] sq1;
  logic [SUM_W-1:0]      sum2;
  logic [2:0][CW-1:0]    mag_in;
  logic [2:0]            neg_in;

  // Square-root stages.
  logic                  sv    [0:SQ_N];
  logic [SUM_W-1:0]      srad  [0:SQ_N];
  logic [ROOT_W+1:0]     srem  [0:SQ_N];
  logic [ROOT_W-1:0]     sroot [0:SQ_N];
  logic [2:0][CW-1:0]    smag  [0:SQ_N];
  logic [2:0]            sneg  [0:SQ_N];

  // Divider stages.
  logic                  dv    [0:DIV_N];
  logic [2:0][REM_W-1:0] drem  [0:DIV_N];
  logic [2:0][DQ_W-1:0]  dq    [0:DIV_N];
  logic [ROOT_W-1:0]     dden  [0:DIV_N];
  logic                  dts   [0:DIV_N];
  logic [2:0]            dneg  [0:DIV_N];

  vec_out_t out_next;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= '0;
    end else if (cfg_valid) begin
      min_length <= cfg_data;
    end
  end

  always_comb begin
    neg_in[0] = in_data.x_in[CW-1];
    neg_in[1] = in_data.y_in[CW-1];
    neg_in[2] = in_data.z_in[CW-1];
    mag_in[0] = neg_in[0] ? CW'(-in_data.x_in) : CW'(in_data.x_in);
    mag_in[1] = neg_in[1] ? CW'(-in_data.y_in) : CW'(in_data.y_in);
    mag_in[2] = neg_in[2] ? CW'(-in_data.z_in) : CW'(in_data.z_in);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag0 <= mag_in;
      neg0 <= neg_in;
      for (int k = 0; k < 3; k++) begin
        sq1[k] <= SUM_W'(mag0[k]) * SUM_W'(mag0[k]);
      end
      mag1 <= mag0;
      neg1 <= neg0;
      sum2 <= sq1[0] + sq1[1] + sq1[2];
      mag2 <= mag1;
      neg2 <= neg1;
    end
  end

  assign sv[0]    = v2;
  assign srad[0]  = sum2;
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign smag[0]  = mag2;
  assign sneg[0]  = neg2;

  // One result bit per stage: bring down two radicand bits, try root*4+1.
  for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
    logic [ROOT_W+1:0] rem_sh;
    logic [ROOT_W+1:0] trial;
    logic              take;

    always_comb begin
      rem_sh = {srem[j][ROOT_W-1:0], srad[j][SUM_W-1 -: 2]};
      trial  = {sroot[j], 2'b01};
      take   = rem_sh >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[j+1] <= 1'b0;
      end else if (en) begin
        sv[j+1] <= sv[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        srad[j+1]  <= {srad[j][SUM_W-3:0], 2'b00};
        srem[j+1]  <= take ? rem_sh - trial : rem_sh;
        sroot[j+1] <= {sroot[j][ROOT_W-2:0], take};
        smag[j+1]  <= smag[j];
        sneg[j+1]  <= sneg[j];
      end
    end
  end

  // Threshold compare; the divider starts with the magnitude as remainder.
  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= sv[SQ_N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        drem[0][k] <= REM_W'(smag[SQ_N][k]);
      end
      dq[0]   <= '0;
      dden[0] <= sroot[SQ_N];
      dts[0]  <= REG_W'(sroot[SQ_N]) <= min_length;
      dneg[0] <= sneg[SQ_N];
    end
  end

  // One quotient bit per stage for each of the three components.
  for (genvar i = 0; i < DIV_N; i++) begin : g_div
    logic [2:0]            take;
    logic [2:0][REM_W-1:0] rem_sub;

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        take[k]    = drem[i][k] >= REM_W'(dden[i]);
        rem_sub[k] = take[k] ? drem[i][k] - REM_W'(dden[i]) : drem[i][k];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[i+1] <= 1'b0;
      end else if (en) begin
        dv[i+1] <= dv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int k = 0; k < 3; k++) begin
          drem[i+1][k] <= {rem_sub[k][REM_W-2:0], 1'b0};
          dq[i+1][k]   <= {dq[i][k][DQ_W-2:0], take[k]};
        end
        dden[i+1] <= dden[i];
        dts[i+1]  <= dts[i];
        dneg[i+1] <= dneg[i];
      end
    end
  end

  always_comb begin
    logic [2:0][CW-1:0] comp;
    for (int k = 0; k < 3; k++) begin
      if (dts[DIV_N]) begin
        comp[k] = '0;
      end else if (dneg[DIV_N][k]) begin
        comp[k] = CW'(-CW'(dq[DIV_N][k]));
      end else begin
        comp[k] = CW'(dq[DIV_N][k]);
      end
    end
    out_next.x_out     = comp[0];
    out_next.y_out     = comp[1];
    out_next.z_out     = comp[2];
    out_next.length    = dden[DIV_N];
    out_next.too_short = dts[DIV_N];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv[DIV_N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= out_next;
    end
  end

endmodule

/* hdl/vector3_normalize_checker.sv */
// Port-level checks for the vector normalizer, bound to the top level.
module vector3_normalize_sva (
  input logic             clk,
  input logic             rst,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input vn_pkg::vec_out_t out_data
);
  import vn_pkg::*;

  localparam logic signed [CW-1:0] ONE     = CW'(1) <<< (CW - 2);
  localparam logic signed [CW-1:0] NEG_ONE = -ONE;

  // A held output beat keeps its contents.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // A short vector gives a zero direction.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.too_short |->
      out_data.x_out == '0 && out_data.y_out == '0 && out_data.z_out == '0)
    else $error("short vector with nonzero direction");

  // Every component of a unit vector stays within plus or minus one.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.too_short |->
      out_data.x_out <= ONE && out_data.x_out >= NEG_ONE &&
      out_data.y_out <= ONE && out_data.y_out >= NEG_ONE &&
      out_data.z_out <= ONE && out_data.z_out >= NEG_ONE)
    else $error("unit vector component out of range");

  // The pipeline never refuses input while the output register is empty.
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // Reset empties the pipeline.
  assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output beat right after reset");

endmodule

bind vector3_normalize vector3_normalize_sva u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
